// ----- rtl/core/slne_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slne_pkg
// Shared sizes, codes and types for the sorted leaf node engine.
// ----------------------------------------------------------------------------
package slne_pkg;

	localparam int CAPACITY   = 8;
	localparam int HALF       = (CAPACITY + 1) / 2;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;
	localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int LEAF_CNT_W = 4;

	typedef struct packed {
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
	} entry_t;

	typedef enum logic [2:0] {
		F_INSERT    = 3'd0,
		F_SEARCH    = 3'd1,
		F_DELETE    = 3'd2,
		F_LOAD_LEAF = 3'd3,
		F_LOAD_SIB  = 3'd4,
		F_CLEAR     = 3'd5,
		F_READ      = 3'd6
	} func_t;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_UPDATED   = 3'd1,
		ST_SPLIT     = 3'd2,
		ST_FOUND     = 3'd3,
		ST_NOT_FOUND = 3'd4,
		ST_DELETED   = 3'd5,
		ST_MERGED    = 3'd6,
		ST_BORROWED  = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		K_STATUS  = 2'd0,
		K_SPLIT   = 2'd1,
		K_SIBLING = 2'd2
	} kind_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_FIND,
		S_INS_SHIFT,
		S_INS_NEW,
		S_SPLIT,
		S_DEL_SHIFT,
		S_DEL_TAIL,
		S_MERGE_SHIFT,
		S_MERGE_COPY,
		S_BORROW_RD,
		S_SIB_SHIFT,
		S_SIB_TAIL,
		S_MAX_RD,
		S_READ,
		S_CLEAR,
		S_STATUS,
		S_STREAM
	} state_t;

endpackage
`default_nettype wire

// ----- rtl/core/sorted_leaf_node_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_leaf_node_engine
// One B+ tree leaf plus one sibling leaf, each in a small synchronous RAM.
//
// A request is taken when start is high and busy is low; busy then stays high
// until the last result of that request has been issued. Every request gives a
// status result first, and split, merge and borrow follow it with streamed
// entries on consecutive cycles. Each result sits on the ports for one cycle
// with strobe high; last marks the final one. The receiver cannot stall.
// Each RAM has a single read port, so entries are read one per cycle: search
// and update scan the leaf; insert scans, shifts larger entries up and writes
// the new one; split scans and then walks the merged sequence; delete scans,
// shifts the entries above the key down, then may merge or borrow and stream
// the sibling entries; load and read touch one slot; clear writes every slot.
// Reset empties both leaves and clears the maximum; RAM contents are not reset.
// ----------------------------------------------------------------------------
module sorted_leaf_node_engine (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           start,
	output logic                          busy,
	input  wire  [2:0]                    func,
	input  wire  [31:0]                   item_key,
	input  wire  [31:0]                   item_value,
	input  wire  signed [1:0]             sibling_side,
	input  wire  [2:0]                    slot,
	output logic                          strobe,
	output logic [2:0]                    status,
	output logic [1:0]                    entry_kind,
	output logic [31:0]                   out_key,
	output logic [31:0]                   out_value,
	output logic [slne_pkg::LEAF_CNT_W-1:0] leaf_count,
	output logic [31:0]                   leaf_max_key,
	output logic [31:0]                   prior_max_key,
	output logic                          last
);
	import slne_pkg::*;

	function automatic logic [IDX_W-1:0] to_idx(input logic [CNT_W-1:0] c);
		return c[IDX_W-1:0];
	endfunction

	entry_t leaf_mem [CAPACITY];
	entry_t sib_mem  [CAPACITY];
	entry_t leaf_rd_q, sib_rd_q;

	logic             leaf_we, sib_we;
	logic [IDX_W-1:0] leaf_wa, sib_wa, leaf_ra, sib_ra;
	entry_t           leaf_wd, sib_wd;

	state_t               state_q, state_d;
	logic [CNT_W-1:0]     cnt_q, cnt_d, pos_q, pos_d, base_q, base_d;
	logic [CNT_W-1:0]     size_q, size_d, sib_size_q, sib_size_d;
	logic [KEY_BITS-1:0]  max_q, max_d, prior_q, rkey_q, rkey_d;
	logic [VALUE_BITS-1:0] rval_q, rval_d;
	entry_t               new_q, new_d;
	status_t              st_q, st_d;
	logic                 stream_q, stream_d;
	func_t                func_q;
	logic                 left_q, right_q;

	logic                 em_valid, em_last;
	status_t              em_status;
	kind_t                em_kind;
	logic [KEY_BITS-1:0]  em_key, em_max;
	logic [VALUE_BITS-1:0] em_value;
	logic [CNT_W-1:0]     em_count;

	logic                 strobe_q, last_q;
	status_t              status_q;
	kind_t                kind_q;
	logic [KEY_BITS-1:0]  okey_q, omax_q, oprior_q;
	logic [VALUE_BITS-1:0] oval_q;
	logic [LEAF_CNT_W-1:0] ocount_q;

	logic                 accept;
	logic [CNT_W-1:0]     m_cnt;
	logic [CNT_W:0]       merged_sum;
	entry_t               split_tk;

	assign accept     = start && !busy;
	assign busy       = (state_q != S_IDLE);
	assign m_cnt      = size_q - CNT_W'(1);
	assign merged_sum = {1'b0, sib_size_q} + {1'b0, m_cnt};
	assign split_tk   = (cnt_q == pos_q) ? new_q : leaf_rd_q;

	// RAMs: one write and one registered read per cycle each
	always_ff @(posedge clk) begin
		if (leaf_we) leaf_mem[leaf_wa] <= leaf_wd;
		leaf_rd_q <= leaf_mem[leaf_ra];
	end

	always_ff @(posedge clk) begin
		if (sib_we) sib_mem[sib_wa] <= sib_wd;
		sib_rd_q <= sib_mem[sib_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			size_q     <= '0;
			sib_size_q <= '0;
			max_q      <= '0;
			stream_q   <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			state_q    <= state_d;
			size_q     <= size_d;
			sib_size_q <= sib_size_d;
			max_q      <= max_d;
			stream_q   <= stream_d;
			strobe_q   <= em_valid;
		end
	end

	always_ff @(posedge clk) begin
		cnt_q  <= cnt_d;
		pos_q  <= pos_d;
		base_q <= base_d;
		rkey_q <= rkey_d;
		rval_q <= rval_d;
		new_q  <= new_d;
		st_q   <= st_d;
		if (accept) begin
			func_q  <= func_t'(func);
			left_q  <= (sibling_side == -2'sd1);
			right_q <= (sibling_side == 2'sd1);
			prior_q <= max_q;
		end
		if (em_valid) begin
			status_q <= em_status;
			kind_q   <= em_kind;
			okey_q   <= em_key;
			oval_q   <= em_value;
			ocount_q <= LEAF_CNT_W'(em_count);
			omax_q   <= em_max;
			oprior_q <= prior_q;
			last_q   <= em_last;
		end
	end

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		pos_d      = pos_q;
		base_d     = base_q;
		size_d     = size_q;
		sib_size_d = sib_size_q;
		max_d      = max_q;
		rkey_d     = rkey_q;
		rval_d     = rval_q;
		new_d      = new_q;
		st_d       = st_q;
		stream_d   = stream_q;
		leaf_we    = 1'b0;
		leaf_wa    = to_idx(cnt_q);
		leaf_wd    = '0;
		sib_we     = 1'b0;
		sib_wa     = to_idx(cnt_q);
		sib_wd     = '0;
		em_valid   = 1'b0;
		em_last    = 1'b0;
		em_status  = st_q;
		em_kind    = K_STATUS;
		em_key     = rkey_q;
		em_value   = rval_q;
		em_count   = size_q;
		em_max     = max_q;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					stream_d = 1'b0;
					rkey_d   = '0;
					rval_d   = '0;
					cnt_d    = '0;
					st_d     = ST_NOT_FOUND;
					state_d  = S_STATUS;
					unique case (func)
						F_INSERT: begin
							rkey_d = item_key;
							rval_d = item_value;
							new_d  = '{key: item_key, value: item_value};
							st_d   = ST_INSERTED;
							pos_d  = '0;
							state_d = (size_q == '0) ? S_INS_NEW : S_FIND;
						end
						F_SEARCH, F_DELETE: begin
							rkey_d = item_key;
							if (size_q != '0) state_d = S_FIND;
						end
						F_LOAD_LEAF: begin
							if (32'(slot) < CAPACITY) begin
								leaf_we = 1'b1;
								leaf_wa = IDX_W'(slot);
								leaf_wd = '{key: item_key, value: item_value};
								size_d  = CNT_W'(32'(slot) + 1);
								max_d   = item_key;
								rkey_d  = item_key;
								rval_d  = item_value;
								st_d    = ST_INSERTED;
							end
						end
						F_LOAD_SIB: begin
							if (32'(slot) < CAPACITY) begin
								sib_we     = 1'b1;
								sib_wa     = IDX_W'(slot);
								sib_wd     = '{key: item_key, value: item_value};
								sib_size_d = CNT_W'(32'(slot) + 1);
								rkey_d     = item_key;
								rval_d     = item_value;
								st_d       = ST_INSERTED;
							end
						end
						F_CLEAR: begin
							size_d     = '0;
							sib_size_d = '0;
							max_d      = '0;
							st_d       = ST_DELETED;
							state_d    = S_CLEAR;
						end
						F_READ: begin
							if (32'(slot) < 32'(size_q)) begin
								cnt_d   = CNT_W'(slot);
								state_d = S_READ;
							end
						end
						default: ;
					endcase
				end
			end

			S_FIND: begin
				if (leaf_rd_q.key == rkey_q) begin
					priority if (func_q == F_INSERT) begin
						leaf_we = 1'b1;
						leaf_wd = '{key: rkey_q, value: rval_q};
						st_d    = ST_UPDATED;
						state_d = S_STATUS;
					end else if (func_q == F_SEARCH) begin
						rval_d  = leaf_rd_q.value;
						st_d    = ST_FOUND;
						state_d = S_STATUS;
					end else begin
						rval_d  = leaf_rd_q.value;
						pos_d   = cnt_q;
						state_d = (cnt_q + CNT_W'(1) == size_q) ? S_DEL_TAIL : S_DEL_SHIFT;
					end
				end else if (func_q == F_INSERT &&
				             (leaf_rd_q.key > rkey_q || cnt_q + CNT_W'(1) == size_q)) begin
					pos_d = (leaf_rd_q.key > rkey_q) ? cnt_q : size_q;
					if (32'(size_q) == CAPACITY) begin
						st_d    = ST_SPLIT;
						cnt_d   = '0;
						state_d = S_SPLIT;
					end else if (pos_d == size_q) begin
						state_d = S_INS_NEW;
					end else begin
						cnt_d   = m_cnt;
						state_d = S_INS_SHIFT;
					end
				end else if (cnt_q + CNT_W'(1) == size_q) begin
					rval_d  = '0;
					st_d    = ST_NOT_FOUND;
					state_d = S_STATUS;
				end else begin
					cnt_d = cnt_q + CNT_W'(1);
				end
			end

			// move entries up one place, top first
			S_INS_SHIFT: begin
				leaf_we = 1'b1;
				leaf_wa = to_idx(cnt_q + CNT_W'(1));
				leaf_wd = leaf_rd_q;
				if (cnt_q == pos_q) state_d = S_INS_NEW;
				else cnt_d = cnt_q - CNT_W'(1);
			end

			S_INS_NEW: begin
				leaf_we = 1'b1;
				leaf_wa = to_idx(pos_q);
				leaf_wd = new_q;
				size_d  = (st_q == ST_BORROWED) ? size_q : size_q + CNT_W'(1);
				cnt_d   = size_d - CNT_W'(1);
				state_d = S_MAX_RD;
			end

			// merged sequence of CAPACITY+1 entries; lower half kept, upper streamed
			S_SPLIT: begin
				leaf_wd = split_tk;
				if (32'(cnt_q) < HALF) begin
					leaf_we = 1'b1;
				end else if (32'(cnt_q) < CAPACITY) begin
					leaf_we = 1'b1;
					leaf_wd = '0;
				end
				if (32'(cnt_q) == HALF - 1) begin
					size_d   = CNT_W'(HALF);
					max_d    = split_tk.key;
					em_valid = 1'b1;
					em_count = CNT_W'(HALF);
					em_max   = split_tk.key;
				end else if (32'(cnt_q) >= HALF) begin
					em_valid = 1'b1;
					em_status = ST_INSERTED;
					em_kind  = K_SPLIT;
					em_key   = split_tk.key;
					em_value = split_tk.value;
					em_last  = (32'(cnt_q) == CAPACITY);
				end
				if (32'(cnt_q) == CAPACITY) state_d = S_IDLE;
				else cnt_d = cnt_q + CNT_W'(1);
			end

			S_DEL_SHIFT: begin
				leaf_we = 1'b1;
				leaf_wd = leaf_rd_q;
				if (cnt_q + CNT_W'(2) == size_q) state_d = S_DEL_TAIL;
				else cnt_d = cnt_q + CNT_W'(1);
			end

			S_DEL_TAIL: begin
				leaf_we = 1'b1;
				leaf_wa = to_idx(m_cnt);
				leaf_wd = '0;
				if (32'(size_q) <= HALF && sib_size_q != '0 && (left_q || right_q)) begin
					stream_d = 1'b1;
					if (32'(merged_sum) <= CAPACITY) begin
						st_d = ST_MERGED;
						priority if (m_cnt == '0) begin
							size_d  = '0;
							state_d = S_STATUS;
						end else if (left_q) begin
							base_d  = sib_size_q;
							cnt_d   = '0;
							state_d = S_MERGE_COPY;
						end else begin
							cnt_d   = sib_size_q - CNT_W'(1);
							state_d = S_MERGE_SHIFT;
						end
					end else begin
						st_d    = ST_BORROWED;
						cnt_d   = left_q ? sib_size_q - CNT_W'(1) : '0;
						state_d = S_BORROW_RD;
					end
				end else begin
					size_d = m_cnt;
					st_d   = ST_DELETED;
					if (m_cnt != '0) begin
						cnt_d   = m_cnt - CNT_W'(1);
						state_d = S_MAX_RD;
					end else begin
						state_d = S_STATUS;
					end
				end
			end

			// right merge: open a gap of m entries at the front of the sibling
			S_MERGE_SHIFT: begin
				sib_we = 1'b1;
				sib_wa = to_idx(cnt_q + m_cnt);
				sib_wd = sib_rd_q;
				if (cnt_q == '0) begin
					base_d  = '0;
					state_d = S_MERGE_COPY;
				end else begin
					cnt_d = cnt_q - CNT_W'(1);
				end
			end

			S_MERGE_COPY: begin
				sib_we  = 1'b1;
				sib_wa  = to_idx(base_q + cnt_q);
				sib_wd  = leaf_rd_q;
				leaf_we = 1'b1;
				leaf_wd = '0;
				if (cnt_q + CNT_W'(2) == size_q) begin
					sib_size_d = merged_sum[CNT_W-1:0];
					size_d     = '0;
					state_d    = S_STATUS;
				end else begin
					cnt_d = cnt_q + CNT_W'(1);
				end
			end

			S_BORROW_RD: begin
				new_d = sib_rd_q;
				if (left_q) begin
					sib_we     = 1'b1;
					sib_wd     = '0;
					sib_size_d = sib_size_q - CNT_W'(1);
					pos_d      = '0;
					if (m_cnt == '0) begin
						state_d = S_INS_NEW;
					end else begin
						cnt_d   = m_cnt - CNT_W'(1);
						state_d = S_INS_SHIFT;
					end
				end else begin
					cnt_d   = '0;
					state_d = (sib_size_q > CNT_W'(1)) ? S_SIB_SHIFT : S_SIB_TAIL;
				end
			end

			S_SIB_SHIFT: begin
				sib_we = 1'b1;
				sib_wd = sib_rd_q;
				if (cnt_q + CNT_W'(2) == sib_size_q) state_d = S_SIB_TAIL;
				else cnt_d = cnt_q + CNT_W'(1);
			end

			S_SIB_TAIL: begin
				sib_we     = 1'b1;
				sib_wa     = to_idx(sib_size_q - CNT_W'(1));
				sib_wd     = '0;
				leaf_we    = 1'b1;
				leaf_wa    = to_idx(m_cnt);
				leaf_wd    = new_q;
				sib_size_d = sib_size_q - CNT_W'(1);
				max_d      = new_q.key;
				state_d    = S_STATUS;
			end

			S_MAX_RD: begin
				// top entry written in the previous cycle was not yet visible to the read
				if (st_q != ST_DELETED && cnt_q == pos_q) max_d = new_q.key;
				else max_d = leaf_rd_q.key;
				state_d = S_STATUS;
			end

			S_READ: begin
				rkey_d  = leaf_rd_q.key;
				rval_d  = leaf_rd_q.value;
				st_d    = ST_FOUND;
				state_d = S_STATUS;
			end

			S_CLEAR: begin
				leaf_we = 1'b1;
				sib_we  = 1'b1;
				if (32'(cnt_q) == CAPACITY - 1) state_d = S_STATUS;
				else cnt_d = cnt_q + CNT_W'(1);
			end

			S_STATUS: begin
				em_valid = 1'b1;
				em_last  = !(stream_q && sib_size_q != '0);
				cnt_d    = '0;
				state_d  = em_last ? S_IDLE : S_STREAM;
			end

			S_STREAM: begin
				em_valid  = 1'b1;
				em_status = ST_INSERTED;
				em_kind   = K_SIBLING;
				em_key    = sib_rd_q.key;
				em_value  = sib_rd_q.value;
				em_last   = (cnt_q + CNT_W'(1) == sib_size_q);
				if (em_last) state_d = S_IDLE;
				else cnt_d = cnt_q + CNT_W'(1);
			end

			default: state_d = S_IDLE;
		endcase
	end

	// read addresses follow the step that comes next
	always_comb begin
		leaf_ra = to_idx(cnt_d);
		sib_ra  = to_idx(cnt_d);
		priority case (state_d)
			S_SPLIT:     leaf_ra = (cnt_d < pos_d) ? to_idx(cnt_d) : to_idx(cnt_d - CNT_W'(1));
			S_DEL_SHIFT: leaf_ra = to_idx(cnt_d + CNT_W'(1));
			S_SIB_SHIFT: sib_ra  = to_idx(cnt_d + CNT_W'(1));
			default: ;
		endcase
	end

	assign strobe        = strobe_q;
	assign status        = status_q;
	assign entry_kind    = kind_q;
	assign out_key       = okey_q;
	assign out_value     = oval_q;
	assign leaf_count    = ocount_q;
	assign leaf_max_key  = omax_q;
	assign prior_max_key = oprior_q;
	assign last          = last_q;

	a_size_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(size_q) <= CAPACITY && 32'(sib_size_q) <= CAPACITY)
		else $error("leaf or sibling count above capacity");

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && last_q |=> !strobe_q)
		else $error("result issued right after a final result");

	a_stream_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && !last_q |=> strobe_q)
		else $error("result stream broken before its final result");

	a_no_result_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !strobe_q)
		else $error("result issued in the cycle after a request was taken");

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives insert, search, delete, load, clear and read requests into the sorted
// leaf node engine and checks every result against a leaf/sibling predictor.
// ----------------------------------------------------------------------------
module testbench;
	import slne_pkg::*;

	localparam logic [2:0] F_UNUSED   = 3'd7;
	localparam logic [1:0] SIDE_NONE  = 2'b00;
	localparam logic [1:0] SIDE_RIGHT = 2'b01;
	localparam logic [1:0] SIDE_ODD   = 2'b10;
	localparam logic [1:0] SIDE_LEFT  = 2'b11;
	localparam int STALL_LIMIT = 3000;

	typedef struct {
		logic [2:0]  status;
		logic [1:0]  kind;
		logic [31:0] key;
		logic [31:0] value;
		logic [3:0]  count;
		logic [31:0] max_key;
		logic [31:0] prior;
		logic        last;
	} leaf_result_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic [2:0]  func = '0;
	logic [31:0] item_key = '0;
	logic [31:0] item_value = '0;
	logic [1:0]  sibling_side = '0;
	logic [2:0]  slot = '0;
	wire         busy, strobe, last;
	wire  [2:0]  status;
	wire  [1:0]  entry_kind;
	wire  [31:0] out_key, out_value, leaf_max_key, prior_max_key;
	wire  [LEAF_CNT_W-1:0] leaf_count;

	sorted_leaf_node_engine dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.item_key(item_key), .item_value(item_value), .sibling_side(sibling_side),
		.slot(slot), .strobe(strobe), .status(status), .entry_kind(entry_kind),
		.out_key(out_key), .out_value(out_value), .leaf_count(leaf_count),
		.leaf_max_key(leaf_max_key), .prior_max_key(prior_max_key), .last(last)
	);

	always #5 clk = ~clk;

	// predicted node state
	logic [31:0] lk [CAPACITY], lv [CAPACITY], sk [CAPACITY], sval [CAPACITY];
	bit          leaf_wr [CAPACITY], sib_wr [CAPACITY];
	int          lcnt, scnt;
	logic [31:0] lmax;

	leaf_result_t pending_results [$];
	int  failures = 0;
	int  idle_cycles = 0;
	int  idle_pct = 0;

	task automatic add_result(ref leaf_result_t b [$], input logic [2:0] st,
			input logic [1:0] kind, input logic [31:0] k, v, prior);
		leaf_result_t r;
		r.status = st; r.kind = kind; r.key = k; r.value = v;
		r.count = lcnt[3:0]; r.max_key = lmax; r.prior = prior; r.last = 0;
		b.push_back(r);
	endtask

	task automatic predict_leaf(input logic [2:0] f, input logic [31:0] k, v,
			input logic [1:0] sd, input logic [2:0] sl);
		leaf_result_t b [$];
		logic [31:0] prior, tk [CAPACITY+1], tv [CAPACITY+1], gone, bk, bv;
		int i, j, pos, n, m, s, side;
		bit hit;
		prior = lmax;
		side  = (sd == SIDE_LEFT) ? -1 : (sd == SIDE_RIGHT) ? 1 : 0;
		case (f)
			F_INSERT: begin
				pos = lcnt; hit = 0;
				for (i = 0; i < lcnt; i++) begin
					if (lk[i] == k) begin
						lv[i] = v; hit = 1; break;
					end
					if (lk[i] > k) begin
						pos = i; break;
					end
				end
				if (hit) add_result(b, ST_UPDATED, K_STATUS, k, v, prior);
				else if (lcnt < CAPACITY) begin
					for (i = lcnt; i > pos; i--) begin
						lk[i] = lk[i-1]; lv[i] = lv[i-1];
					end
					lk[pos] = k; lv[pos] = v; lcnt++;
					lmax = lk[lcnt-1];
					add_result(b, ST_INSERTED, K_STATUS, k, v, prior);
				end else begin
					n = 0;
					for (i = 0; i < CAPACITY; i++) begin
						if (i == pos) begin
							tk[n] = k; tv[n] = v; n++;
						end
						tk[n] = lk[i]; tv[n] = lv[i]; n++;
					end
					if (pos >= CAPACITY) begin
						tk[n] = k; tv[n] = v; n++;
					end
					for (i = 0; i < CAPACITY; i++) begin
						lk[i] = (i < HALF) ? tk[i] : '0;
						lv[i] = (i < HALF) ? tv[i] : '0;
					end
					lcnt = HALF; lmax = tk[HALF-1];
					add_result(b, ST_SPLIT, K_STATUS, k, v, prior);
					for (i = HALF; i < n; i++)
						add_result(b, ST_INSERTED, K_SPLIT, tk[i], tv[i], prior);
				end
			end
			F_SEARCH: begin
				hit = 0;
				for (i = 0; i < lcnt; i++)
					if (!hit && lk[i] == k) begin
						add_result(b, ST_FOUND, K_STATUS, k, lv[i], prior); hit = 1;
					end
				if (!hit) add_result(b, ST_NOT_FOUND, K_STATUS, k, '0, prior);
			end
			F_DELETE: begin
				n = lcnt; i = 0;
				while (i < n && lk[i] != k) i++;
				if (i >= n) add_result(b, ST_NOT_FOUND, K_STATUS, k, '0, prior);
				else begin
					gone = lv[i];
					for (j = i; j + 1 < n; j++) begin
						lk[j] = lk[j+1]; lv[j] = lv[j+1];
					end
					lk[n-1] = '0; lv[n-1] = '0; m = n - 1;
					if (n <= HALF && scnt != 0 && side != 0) begin
						s = scnt;
						if (s + m <= CAPACITY) begin
							if (side == -1) begin
								for (j = 0; j < m; j++) begin
									sk[s+j] = lk[j]; sval[s+j] = lv[j];
								end
							end else begin
								for (j = s; j > 0; j--) begin
									sk[j-1+m] = sk[j-1]; sval[j-1+m] = sval[j-1];
								end
								for (j = 0; j < m; j++) begin
									sk[j] = lk[j]; sval[j] = lv[j];
								end
							end
							for (j = 0; j < m; j++) begin
								lk[j] = '0; lv[j] = '0;
							end
							scnt = s + m; lcnt = 0;
							add_result(b, ST_MERGED, K_STATUS, k, gone, prior);
						end else begin
							if (side == -1) begin
								bk = sk[s-1]; bv = sval[s-1];
								sk[s-1] = '0; sval[s-1] = '0;
								for (j = m; j > 0; j--) begin
									lk[j] = lk[j-1]; lv[j] = lv[j-1];
								end
								lk[0] = bk; lv[0] = bv;
							end else begin
								bk = sk[0]; bv = sval[0];
								for (j = 0; j + 1 < s; j++) begin
									sk[j] = sk[j+1]; sval[j] = sval[j+1];
								end
								sk[s-1] = '0; sval[s-1] = '0;
								lk[n-1] = bk; lv[n-1] = bv;
							end
							scnt = s - 1; lcnt = n; lmax = lk[n-1];
							add_result(b, ST_BORROWED, K_STATUS, k, gone, prior);
						end
						for (j = 0; j < scnt; j++)
							add_result(b, ST_INSERTED, K_SIBLING, sk[j], sval[j], prior);
					end else begin
						lcnt = m;
						if (m > 0) lmax = lk[m-1];  // emptied leaf keeps its old maximum
						add_result(b, ST_DELETED, K_STATUS, k, gone, prior);
					end
				end
			end
			F_LOAD_LEAF: begin
				lk[sl] = k; lv[sl] = v; lcnt = sl + 1; lmax = k;
				add_result(b, ST_INSERTED, K_STATUS, k, v, prior);
			end
			F_LOAD_SIB: begin
				sk[sl] = k; sval[sl] = v; scnt = sl + 1;
				add_result(b, ST_INSERTED, K_STATUS, k, v, prior);
			end
			F_CLEAR: begin
				for (i = 0; i < CAPACITY; i++) begin
					lk[i] = '0; lv[i] = '0; sk[i] = '0; sval[i] = '0;
					leaf_wr[i] = 1; sib_wr[i] = 1;
				end
				lcnt = 0; scnt = 0; lmax = '0;
				add_result(b, ST_DELETED, K_STATUS, '0, '0, prior);
			end
			F_READ: begin
				if (sl < lcnt) add_result(b, ST_FOUND, K_STATUS, lk[sl], lv[sl], prior);
				else add_result(b, ST_NOT_FOUND, K_STATUS, '0, '0, prior);
			end
			default: add_result(b, ST_NOT_FOUND, K_STATUS, '0, '0, prior);
		endcase
		for (i = 0; i < lcnt; i++) leaf_wr[i] = 1;
		for (i = 0; i < scnt; i++) sib_wr[i] = 1;
		b[b.size()-1].last = 1;
		foreach (b[i]) pending_results.push_back(b[i]);
	endtask

	// hold start until the request is taken, then an optional random gap
	task automatic send_request(input logic [2:0] f, input logic [31:0] k, v,
			input logic [1:0] sd, input logic [2:0] sl);
		func <= f; item_key <= k; item_value <= v; sibling_side <= sd; slot <= sl;
		start <= 1;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		predict_leaf(f, k, v, sd, sl);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			start <= 0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	// slot for a load: never leaves unwritten entries below the new count
	function automatic logic [2:0] safe_slot(input bit sibling);
		int s, i;
		bit ok;
		s = $urandom_range(0, CAPACITY - 1);
		ok = 1;
		for (i = 0; i < s; i++)
			if (!(sibling ? sib_wr[i] : leaf_wr[i])) ok = 0;
		if (!ok) s = sibling ? scnt : lcnt;
		if (s > CAPACITY - 1) s = CAPACITY - 1;
		return s[2:0];
	endfunction

	function automatic logic [31:0] pick_key();
		if (lcnt > 0 && $urandom_range(0, 1)) return lk[$urandom_range(0, lcnt - 1)];
		if ($urandom_range(0, 7) == 0) return $urandom;
		return $urandom_range(0, 40);
	endfunction

	task automatic test_directed();
		int i;
		send_request(F_READ, 0, 0, SIDE_NONE, 0);
		send_request(F_SEARCH, 32'hFFFF_FFFF, 0, SIDE_NONE, 0);
		send_request(F_DELETE, 0, 0, SIDE_LEFT, 0);
		send_request(F_INSERT, 32'h0, 32'h0, SIDE_NONE, 0);
		send_request(F_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, SIDE_NONE, 7);
		send_request(F_INSERT, 32'h0, 32'hA5A5_5A5A, SIDE_NONE, 0);
		send_request(F_SEARCH, 32'h0, 0, SIDE_NONE, 0);
		send_request(F_SEARCH, 32'h1234, 0, SIDE_NONE, 0);
		for (i = 0; i < 6; i++)
			send_request(F_INSERT, 32'h1000 * (i + 1), $urandom, SIDE_NONE, 0);
		send_request(F_INSERT, 32'h8000_0000, $urandom, SIDE_NONE, 0);  // full: split
		send_request(F_READ, 3'd7, 0, SIDE_NONE, 7);
		send_request(F_READ, 0, 0, SIDE_NONE, 3);
		send_request(F_DELETE, 32'h1000, 0, SIDE_ODD, 0);
		send_request(F_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, SIDE_LEFT, 7);
		send_request(F_CLEAR, 0, 0, SIDE_NONE, 0);
	endtask

	task automatic test_merge_borrow();
		int i;
		for (i = 0; i < CAPACITY; i++)
			send_request(F_LOAD_SIB, 32'h100 + i, $urandom, SIDE_NONE, 3'(i));
		for (i = 0; i < HALF; i++)
			send_request(F_INSERT, 32'h10 + i, $urandom, SIDE_NONE, 0);
		send_request(F_DELETE, 32'h11, 0, SIDE_RIGHT, 0);  // borrow from right
		send_request(F_DELETE, 32'h12, 0, SIDE_LEFT, 0);   // borrow from left
		send_request(F_CLEAR, 0, 0, SIDE_NONE, 0);
		send_request(F_LOAD_SIB, 32'h5, 32'h55, SIDE_NONE, 0);
		send_request(F_LOAD_LEAF, 32'h20, 32'h22, SIDE_NONE, 0);
		send_request(F_LOAD_LEAF, 32'h30, 32'h33, SIDE_NONE, 1);
		send_request(F_DELETE, 32'h20, 0, SIDE_LEFT, 0);   // merge into left
		send_request(F_INSERT, 32'h40, 32'h44, SIDE_NONE, 0);
		send_request(F_DELETE, 32'h40, 0, SIDE_RIGHT, 0);  // merge of the only entry
		send_request(F_READ, 0, 0, SIDE_NONE, 0);
		send_request(F_DELETE, 32'h5, 0, SIDE_NONE, 0);
	endtask

	task automatic test_random(input int n, input int pct);
		int i, r;
		logic [2:0] f, sl;
		idle_pct = pct;
		for (i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			sl = 3'($urandom);
			if (r < 36) f = F_INSERT;
			else if (r < 62) f = F_DELETE;
			else if (r < 74) f = F_SEARCH;
			else if (r < 83) begin
				f = F_LOAD_SIB; sl = safe_slot(1);
			end else if (r < 88) begin
				f = F_LOAD_LEAF; sl = safe_slot(0);
			end else if (r < 95) f = F_READ;
			else if (r < 98) f = F_CLEAR;
			else f = F_UNUSED;
			send_request(f, pick_key(), $urandom, 2'($urandom), sl);
		end
		start <= 0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		leaf_result_t e;
		if (arst_n) begin
			if ((start && !busy) || strobe) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles > STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
			if (strobe) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result status %0d key %h", $time, status, out_key);
					failures++;
				end else begin
					e = pending_results.pop_front();
					if (status !== e.status || entry_kind !== e.kind || out_key !== e.key ||
							out_value !== e.value || leaf_count !== e.count ||
							leaf_max_key !== e.max_key || prior_max_key !== e.prior ||
							last !== e.last) begin
						$display("%0t: mismatch exp st %0d kind %0d key %h val %h cnt %0d max %h prior %h last %0d",
							$time, e.status, e.kind, e.key, e.value, e.count, e.max_key,
							e.prior, e.last);
						$display("%0t:          got st %0d kind %0d key %h val %h cnt %0d max %h prior %h last %0d",
							$time, status, entry_kind, out_key, out_value, leaf_count,
							leaf_max_key, prior_max_key, last);
						failures++;
					end
				end
			end
		end
	end

	initial begin
		int i;
		for (i = 0; i < CAPACITY; i++) begin
			lk[i] = '0; lv[i] = '0; sk[i] = '0; sval[i] = '0;
			leaf_wr[i] = 0; sib_wr[i] = 0;
		end
		lcnt = 0; scnt = 0; lmax = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_merge_borrow();
		test_random(100, 0);
		test_random(100, 74);
		test_random(80, 14);
		test_random(60, 0);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (failures == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

endmodule
